FILE: rtl/sync_length_frame_deframer_assert.svh
// ---------------------------------------------------------------------------
// sync_length_frame_deframer assertion macros
// Shared concurrent assertion forms for the deframer.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slfd assertion failed");

// next-cycle implication, disabled in reset
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slfd assertion failed");

`endif

FILE: rtl/slfd_pkg.sv
// ---------------------------------------------------------------------------
// slfd_pkg
// Types and constants shared by the sync/length frame deframer.
// ---------------------------------------------------------------------------
package slfd_pkg;

    localparam logic [7:0]  SYNC_RESET    = 8'hA5;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    // configuration register indexes
    localparam logic REG_SYNC    = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      fill;
    } t_win;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last_byte;
        logic [15:0] frame_length;
    } t_result;

endpackage

FILE: rtl/slfd_window.sv
// ---------------------------------------------------------------------------
// slfd_window
// Appends a hunted byte to the header window and runs the resync cascade.
// ---------------------------------------------------------------------------
module slfd_window
    import slfd_pkg::*;
(
    input  t_win        i_win,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_sync,
    input  logic [15:0] i_max_len,
    output t_win        o_win
);

    t_win w;
    logic done;

    always_comb begin
        w = i_win;
        done = 1'b0;
        w.bytes[w.fill] = i_byte;
        w.fill = w.fill + 2'd1;
        for (int g = 0; g < 3; g++) begin
            if (!done && w.fill != 2'd0) begin
                if (w.bytes[0] != i_sync ||
                    (w.fill == 2'd3 && {w.bytes[1], w.bytes[2]} > i_max_len)) begin
                    w.bytes[0] = w.bytes[1];
                    w.bytes[1] = w.bytes[2];
                    w.bytes[2] = 8'd0;
                    w.fill = w.fill - 2'd1;
                end else begin
                    done = 1'b1;
                end
            end
        end
    end

    assign o_win = w;

endmodule

FILE: rtl/slfd_out_reg.sv
// ---------------------------------------------------------------------------
// slfd_out_reg
// Result register on the master side; frees itself when the request is taken.
// ---------------------------------------------------------------------------
module slfd_out_reg
    import slfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_free,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata,   // data_byte[7:0], frame_length[23:8]
    output logic        o_m_tlast,
    output logic [8:0]  o_m_tuser    // frame_type[7:0], has_data[8]
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_res.frame_length, r_res.data_byte};
    assign o_m_tlast  = r_res.last_byte;
    assign o_m_tuser  = {r_res.has_data, r_res.frame_type};

endmodule

FILE: rtl/sync_length_frame_deframer.sv
// ---------------------------------------------------------------------------
// sync_length_frame_deframer
// Finds sync/length/type headers in a byte stream and streams out payload.
// ---------------------------------------------------------------------------
// Takes one byte per clock while o_s_tready is high and gives at most one result
// per byte; each byte is handled in the cycle it is accepted and its result sits
// in a single output register in the cycle after. o_s_tready is low only while
// that register holds a result the master side has not taken. Header bytes give
// no result; payload bytes come out tagged with type and length, tlast on the
// last one, and a zero-length frame gives one result with tuser[8] low.
// Configuration writes are always ready and take effect on the next byte.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer
    import slfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // data_byte[7:0], frame_length[23:8]
    output logic        o_m_tlast,   // last_byte
    output logic [8:0]  o_m_tuser,   // frame_type[7:0], has_data[8]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "sync_length_frame_deframer_assert.svh"

    localparam logic PH_HUNT    = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    logic        r_sync, n_unused;
    logic [7:0]  r_sync_value;
    logic [15:0] r_max_len;
    t_win        r_win, n_win;
    logic        r_phase, n_phase;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;

    t_win        hunt_win;
    t_result     res;
    logic        res_valid;
    logic        accept;
    logic        free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = free;
    assign accept      = i_s_tvalid && free;

    // register write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_max_len    <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SYNC:    r_sync_value <= i_cfg_data[7:0];
                REG_MAX_LEN: r_max_len    <= i_cfg_data;
                default:     r_max_len    <= r_max_len;
            endcase
        end
    end

    slfd_window u_window (
        .i_win     (r_win),
        .i_byte    (i_s_tdata),
        .i_sync    (r_sync_value),
        .i_max_len (r_max_len),
        .o_win     (hunt_win)
    );

    always_comb begin
        n_win     = r_win;
        n_phase   = r_phase;
        n_left    = r_left;
        n_type    = r_type;
        n_len     = r_len;
        res_valid = 1'b0;
        res       = '0;
        if (r_phase == PH_PAYLOAD) begin
            res_valid        = 1'b1;
            res.frame_type   = r_type;
            res.data_byte    = i_s_tdata;
            res.has_data     = 1'b1;
            res.last_byte    = (r_left <= 16'd1);
            res.frame_length = r_len;
            if (r_left <= 16'd1) begin
                n_left  = 16'd0;
                n_phase = PH_HUNT;
                n_win   = '0;
            end else begin
                n_left = r_left - 16'd1;
            end
        end else if (r_win.fill == 2'd3) begin
            n_type = i_s_tdata;
            n_len  = {r_win.bytes[1], r_win.bytes[2]};
            n_win  = '0;
            if ({r_win.bytes[1], r_win.bytes[2]} == 16'd0) begin
                res_valid        = 1'b1;
                res.frame_type   = i_s_tdata;
                res.last_byte    = 1'b1;
            end else begin
                n_left  = {r_win.bytes[1], r_win.bytes[2]};
                n_phase = PH_PAYLOAD;
            end
        end else begin
            n_win = hunt_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_phase <= PH_HUNT;
            r_left  <= 16'd0;
            r_type  <= 8'd0;
            r_len   <= 16'd0;
        end else if (accept) begin
            r_win   <= n_win;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_type  <= n_type;
            r_len   <= n_len;
        end
    end

    // marks a stall cycle with a result pending; used by the checks below
    assign n_unused = o_m_tvalid && !i_m_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 1'b0;
        end else begin
            r_sync <= n_unused;
        end
    end

    slfd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res_valid),
        .i_result   (res),
        .o_free     (free),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    `SLFD_ASSERT_NOW(a_payload_win_empty, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_win.fill == 2'd0)
    `SLFD_ASSERT_NOW(a_payload_left_nz, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_left != 16'd0)
    `SLFD_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, accept && r_phase == PH_PAYLOAD && r_left <= 16'd1, r_phase == PH_HUNT)
    `SLFD_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, r_sync && o_m_tvalid && !i_m_tready, !o_s_tready)

endmodule

FILE: tb/sync_length_frame_deframer_tb.sv
// ---------------------------------------------------------------------------
// sync_length_frame_deframer_tb
// Self-checking bench for the sync/length/type frame deframer. A queue-fed
// driver streams bytes into the slave side, and an in-bench deframer model
// predicts each result. A monitor compares every master-side result, field by
// field, against the oldest prediction. A short directed run covers resync
// cascades, header acceptance across register writes, zero-length frames and
// length limits. Random phases then follow under several register settings
// and idle/stall mixes.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer_tb
    import slfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic [8:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_SYNC;
    logic [15:0] i_cfg_data  = 16'h0000;

    sync_length_frame_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    logic [7:0] rx_pending[$];
    t_result    pending_results[$];
    int         queued_bytes   = 0;
    int         fail_count     = 0;
    int         idle_cycles    = 0;
    int         send_idle_pct  = 10;
    int         recv_stall_pct = 75;

    // deframer model state
    logic [7:0]  cur_sync;
    logic [15:0] cur_max;
    logic [7:0]  hdr_win[3];
    logic [1:0]  hdr_fill;
    bit          in_payload;
    logic [15:0] bytes_left;
    logic [7:0]  held_type;
    logic [15:0] held_len;

    function automatic void clear_window();
        hdr_win[0] = 8'h00;
        hdr_win[1] = 8'h00;
        hdr_win[2] = 8'h00;
        hdr_fill   = 2'd0;
    endfunction

    function automatic bit predict_deframe(input logic [7:0] b, output t_result r);
        int g;
        bit settled;
        r = '0;
        if (in_payload) begin
            r.frame_type   = held_type;
            r.data_byte    = b;
            r.has_data     = 1'b1;
            r.last_byte    = (bytes_left <= 16'd1);
            r.frame_length = held_len;
            if (r.last_byte) begin
                bytes_left = 16'd0;
                in_payload = 1'b0;
                clear_window();
            end else begin
                bytes_left = bytes_left - 16'd1;
            end
            return 1'b1;
        end
        if (hdr_fill == 2'd3) begin
            held_type = b;
            held_len  = {hdr_win[1], hdr_win[2]};
            clear_window();
            if (held_len == 16'd0) begin
                r.frame_type = held_type;
                r.last_byte  = 1'b1;
                return 1'b1;
            end
            bytes_left = held_len;
            in_payload = 1'b1;
            return 1'b0;
        end
        hdr_win[hdr_fill] = b;
        hdr_fill = hdr_fill + 2'd1;
        settled = 1'b0;
        for (g = 0; g < 3; g++) begin
            if (!settled && hdr_fill != 2'd0) begin
                if (hdr_win[0] != cur_sync ||
                    (hdr_fill == 2'd3 && {hdr_win[1], hdr_win[2]} > cur_max)) begin
                    hdr_win[0] = hdr_win[1];
                    hdr_win[1] = hdr_win[2];
                    hdr_win[2] = 8'h00;
                    hdr_fill   = hdr_fill - 2'd1;
                end else begin
                    settled = 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= rx_pending.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // model, result checker and watchdog
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result next_r;
        if (!i_rst_n) begin
            cur_sync    = SYNC_RESET;
            cur_max     = MAX_LEN_RESET;
            in_payload  = 1'b0;
            bytes_left  = 16'd0;
            held_type   = 8'h00;
            held_len    = 16'd0;
            idle_cycles = 0;
            clear_window();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.frame_type   = o_m_tuser[7:0];
                got.has_data     = o_m_tuser[8];
                got.data_byte    = o_m_tdata[7:0];
                got.frame_length = o_m_tdata[23:8];
                got.last_byte    = o_m_tlast;
                if (pending_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: type %02h data %02h has %0b last %0b len %0d",
                                 got.frame_type, got.data_byte, got.has_data,
                                 got.last_byte, got.frame_length);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.frame_type !== want.frame_type || got.data_byte !== want.data_byte ||
                        got.has_data !== want.has_data || got.last_byte !== want.last_byte ||
                        got.frame_length !== want.frame_length) begin
                        if (fail_count < 10)
                            $display("mismatch exp/act: type %02h/%02h data %02h/%02h %s%0b/%0b %s%0b/%0b %s%0d/%0d",
                                     want.frame_type, got.frame_type,
                                     want.data_byte, got.data_byte,
                                     "has ", want.has_data, got.has_data,
                                     "last ", want.last_byte, got.last_byte,
                                     "len ", want.frame_length, got.frame_length);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                if (predict_deframe(i_s_tdata, next_r))
                    pending_results.push_back(next_r);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SYNC:    cur_sync = i_cfg_data[7:0];
                    REG_MAX_LEN: cur_max  = i_cfg_data;
                    default:     ;
                endcase
            end
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    task automatic add_noise(input int n);
        logic [7:0] v;
        repeat (n) begin
            v = 8'($urandom_range(255));
            // stray sync bytes only where a long bogus length cannot pass the limit
            if (v == cur_sync && (cur_max >= 16'd256 || $urandom_range(3) != 0))
                v = v ^ 8'h80;
            push_byte(v);
        end
    endtask

    task automatic add_frame(input int len);
        push_byte(cur_sync);
        push_byte(8'(len >> 8));
        push_byte(8'(len));
        push_byte(8'($urandom_range(255)));
        repeat (len) push_byte(8'($urandom_range(255)));
    endtask

    task automatic add_random_unit();
        int          pick;
        int          lim;
        int          tries;
        bit          ok;
        logic [15:0] bad;
        pick = $urandom_range(99);
        if (pick < 70) begin
            lim = (cur_max < 16'd12) ? int'(cur_max) : 12;
            if ($urandom_range(24) == 0)
                lim = (cur_max < 16'd200) ? int'(cur_max) : 200;
            add_frame($urandom_range(lim));
        end else if (pick < 82) begin
            add_noise($urandom_range(4, 1));
        end else if (pick < 92) begin
            ok  = 1'b0;
            bad = 16'h0000;
            for (tries = 0; tries < 8; tries++) begin
                if (!ok && cur_max != 16'hFFFF) begin
                    bad = 16'($urandom_range(65535, int'(cur_max) + 1));
                    ok  = (bad[15:8] != cur_sync) && (bad[7:0] != cur_sync);
                end
            end
            if (ok) begin
                push_byte(cur_sync);
                push_byte(bad[15:8]);
                push_byte(bad[7:0]);
            end else begin
                add_noise(1);
            end
        end else begin
            // truncated header
            push_byte(cur_sync);
            push_byte((cur_max >= 16'd256) ? 8'h00 : 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_pending.size() != 0 || i_s_tvalid || pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] sync, input logic [15:0] max_len,
                             input int send_pct, input int recv_pct, input int n);
        int start;
        wait_drained();
        cfg_write(REG_SYNC, {8'h00, sync});
        cfg_write(REG_MAX_LEN, max_len);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = queued_bytes;
        while (queued_bytes - start < n) add_random_unit();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // leading junk, zero-length frame, two-byte frame, sync run with single drops,
        // header left waiting for its type byte
        push_byte(8'h00);
        push_byte(8'hA5); push_byte(8'h00); push_byte(8'h00); push_byte(8'h07);
        push_byte(8'hA5); push_byte(8'h00); push_byte(8'h02); push_byte(8'h3C);
        push_byte(8'hFF); push_byte(8'h00);
        push_byte(8'hA5); push_byte(8'hA5); push_byte(8'hA5); push_byte(8'h00);
        push_byte(8'h01);
        wait_drained();
        cfg_write(REG_MAX_LEN, 16'd0);

        // held header still taken, then length one over the limit, then partial window
        push_byte(8'h80); push_byte(8'h55);
        push_byte(8'hA5); push_byte(8'h00); push_byte(8'h01);
        push_byte(8'hA5); push_byte(8'h00);
        wait_drained();
        cfg_write(REG_SYNC, 16'h003C);
        cfg_write(REG_MAX_LEN, 16'd3);

        // old partial window rechecked against the new sync, length at the limit
        push_byte(8'h3C); push_byte(8'h00); push_byte(8'h03); push_byte(8'h01);
        push_byte(8'hAA); push_byte(8'hBB); push_byte(8'hCC);

        run_phase(8'hA5, 16'd4096, 10, 75, 140);
        run_phase(8'h00, 16'd0, 10, 75, 140);
        run_phase(8'hFF, 16'hFFFF, 75, 10, 140);
        run_phase(8'($urandom_range(255)), 16'($urandom_range(40, 1)), 75, 10, 140);
        run_phase(8'($urandom_range(255)), 16'd255, 0, 0, 140);
        run_phase(8'hA5, 16'd20, 0, 0, 110);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sync_length_frame_deframer.f
+incdir+rtl
rtl/slfd_pkg.sv
rtl/slfd_window.sv
rtl/slfd_out_reg.sv
rtl/sync_length_frame_deframer.sv
tb/sync_length_frame_deframer_tb.sv
